// ===== rtl/mpd_pkg.sv =====
// Shared types and constants for the mesh partial derivatives unit.
// No dependencies; imported by every module of the block.
package mpd_pkg;

	localparam int MAX_PHI_DEF   = 32;
	localparam int MAX_THETA_DEF = 4096;

	localparam int DATA_W    = 32;
	localparam int ROW_W     = 12;
	localparam int COL_W     = 5;
	localparam int NT_W      = 13;
	localparam int NP_W      = 6;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_N_THETA    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_N_PHI      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DTHETA = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DPHI   = 2'd3;

	localparam logic [NT_W-1:0]   N_THETA_RST = 13'd2;
	localparam logic [NP_W-1:0]   N_PHI_RST   = 6'd2;
	localparam logic [DATA_W-1:0] INV_RST     = 32'h0001_0000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_T,
		ST_RD_P,
		ST_MTL,
		ST_MTH,
		ST_MPL,
		ST_MPH,
		ST_MACC,
		ST_OUT
	} mpd_state_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	typedef struct packed {
		logic             wr_en;
		logic             rd_en;
		logic             lat_t;
		logic             lat_p;
		logic             mul_en;
		logic             mul_p;
		logic             mul_hi;
		acc_op_t          acc_op;
		logic             sav_t;
		logic             sh17;
		logic             out_load;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             final_pt;
	} mpd_cmd_t;

endpackage

// ===== rtl/mpd_datapath.sv =====
// Datapath: three-row sample store, difference registers, shared 17x33
// multiplier with 66-bit accumulator, saturation and output register.
// Depends on mpd_pkg; driven by mpd_ctrl commands.
module mpd_datapath #(
	parameter int MAX_PHI = mpd_pkg::MAX_PHI_DEF
) (
	input  logic                              clk,
	input  mpd_pkg::mpd_cmd_t                 cmd,
	input  logic [$clog2(3*MAX_PHI)-1:0]      wr_addr,
	input  logic [$clog2(3*MAX_PHI)-1:0]      rd_addr0,
	input  logic [$clog2(3*MAX_PHI)-1:0]      rd_addr1,
	input  logic signed [mpd_pkg::DATA_W-1:0] sample,
	input  logic [mpd_pkg::DATA_W-1:0]        inv_dtheta,
	input  logic [mpd_pkg::DATA_W-1:0]        inv_dphi,
	output logic signed [mpd_pkg::DATA_W-1:0] d_theta,
	output logic signed [mpd_pkg::DATA_W-1:0] d_phi,
	output logic [mpd_pkg::ROW_W-1:0]         row,
	output logic [mpd_pkg::COL_W-1:0]         col,
	output logic                              clipped,
	output logic                              final_point
);
	import mpd_pkg::*;

	localparam int DEPTH  = 3 * MAX_PHI;
	localparam int ACC_W  = 66;
	localparam int PROD_W = 50;
	localparam logic signed [ACC_W-1:0] POS_MAX = ACC_W'(64'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] NEG_MIN = ACC_W'(-64'sh8000_0000);

	logic [DATA_W-1:0] mem [DEPTH];
	logic signed [DATA_W-1:0] rdata0_q, rdata1_q;
	logic signed [DATA_W:0]   diff_t_q, diff_p_q, diff_sel;
	logic signed [16:0]       mul_a;
	logic signed [DATA_W:0]   mul_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [DATA_W-1:0] dt_q;
	logic                     clip_t_q;
	logic [DATA_W:0]          sat_t, sat_p;

	// {clip, value}
	function automatic logic [DATA_W:0] sat32(input logic signed [ACC_W-1:0] v,
		input logic sh17);
		logic signed [ACC_W-1:0] s;
		s = sh17 ? (v >>> 17) : (v >>> 16);
		if (s > POS_MAX) begin
			return {1'b1, 32'h7FFF_FFFF};
		end else if (s < NEG_MIN) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, s[DATA_W-1:0]};
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= sample;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata0_q <= mem[rd_addr0];
			rdata1_q <= mem[rd_addr1];
		end
	end

	assign diff_sel = cmd.mul_p ? diff_p_q : diff_t_q;
	assign mul_a    = cmd.mul_hi ? diff_sel[DATA_W:16] : $signed({1'b0, diff_sel[15:0]});
	assign mul_b    = $signed({1'b0, (cmd.mul_p ? inv_dphi : inv_dtheta)});
	assign sat_t    = sat32(acc_q, cmd.sh17);
	assign sat_p    = sat32(acc_q, 1'b1);

	always_ff @(posedge clk) begin
		if (cmd.lat_t) begin
			diff_t_q <= (DATA_W+1)'(rdata0_q) - (DATA_W+1)'(rdata1_q);
		end
		if (cmd.lat_p) begin
			diff_p_q <= (DATA_W+1)'(rdata0_q) - (DATA_W+1)'(rdata1_q);
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (cmd.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + (ACC_W'(prod_q) <<< 16);
			default:  acc_q <= acc_q;
		endcase
		if (cmd.sav_t) begin
			dt_q     <= sat_t[DATA_W-1:0];
			clip_t_q <= sat_t[DATA_W];
		end
		if (cmd.out_load) begin
			d_theta     <= dt_q;
			d_phi       <= sat_p[DATA_W-1:0];
			clipped     <= clip_t_q | sat_p[DATA_W];
			row         <= cmd.row;
			col         <= cmd.col;
			final_point <= cmd.final_pt;
		end
	end

endmodule

// ===== rtl/mpd_ctrl.sv =====
// Controller: mesh row/column counters, row-store slot ring, per-point
// sequencing state machine and output valid. Depends on mpd_pkg.
module mpd_ctrl #(
	parameter int MAX_PHI   = mpd_pkg::MAX_PHI_DEF,
	parameter int MAX_THETA = mpd_pkg::MAX_THETA_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [mpd_pkg::NT_W-1:0]      n_theta,
	input  logic [mpd_pkg::NP_W-1:0]      n_phi,
	input  logic                          in_valid,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mpd_pkg::mpd_cmd_t             cmd,
	output logic [$clog2(3*MAX_PHI)-1:0]  wr_addr,
	output logic [$clog2(3*MAX_PHI)-1:0]  rd_addr0,
	output logic [$clog2(3*MAX_PHI)-1:0]  rd_addr1
);
	import mpd_pkg::*;

	localparam int AW = $clog2(3 * MAX_PHI);
	localparam int CW = $clog2(MAX_PHI);
	localparam int RW = $clog2(MAX_THETA);
	localparam int TW = $clog2(MAX_THETA + 1);
	localparam int PW = $clog2(MAX_PHI + 1);

	mpd_state_t state_q, state_d;

	logic [RW-1:0] row_q, pt_row_q, last_row_q, r_cur;
	logic [CW-1:0] col_q, pt_col_q, c_cur, np_m1, cp, cm;
	logic [1:0]    slot_q, cur_slot_q, s_cur, b_slot, p_slot;
	logic          fwd_q, flush_q, in_flush_q, pt_final_q, out_valid_q;
	logic [TW-1:0] nt;
	logic [PW-1:0] np;
	logic          accept, restart, is_last, col_end, out_free, more;

	function automatic logic [1:0] slot_prev(input logic [1:0] s);
		return (s == 2'd0) ? 2'd2 : s - 2'd1;
	endfunction

	function automatic logic [1:0] slot_next(input logic [1:0] s);
		return (s == 2'd2) ? 2'd0 : s + 2'd1;
	endfunction

	function automatic logic [AW-1:0] mem_addr(input logic [1:0] s, input logic [CW-1:0] c);
		return AW'(32'(s) * MAX_PHI + 32'(c));
	endfunction

	always_comb begin
		if (n_theta < NT_W'(2)) begin
			nt = TW'(2);
		end else if (32'(n_theta) > 32'(MAX_THETA)) begin
			nt = TW'(MAX_THETA);
		end else begin
			nt = TW'(n_theta);
		end
		if (n_phi < NP_W'(2)) begin
			np = PW'(2);
		end else if (32'(n_phi) > 32'(MAX_PHI)) begin
			np = PW'(MAX_PHI);
		end else begin
			np = PW'(n_phi);
		end
	end

	assign np_m1    = CW'(32'(np) - 32'd1);
	assign restart  = (32'(row_q) >= 32'(nt)) || (32'(col_q) >= 32'(np));
	assign r_cur    = restart ? '0 : row_q;
	assign c_cur    = restart ? '0 : col_q;
	assign s_cur    = restart ? 2'd0 : slot_q;
	assign col_end  = (c_cur == np_m1);
	assign is_last  = (32'(r_cur) == 32'(nt) - 32'd1) && col_end;
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign more     = in_flush_q ? (pt_col_q != np_m1) : flush_q;
	assign out_valid = out_valid_q;

	assign b_slot = (in_flush_q || fwd_q) ? slot_prev(cur_slot_q)
		: slot_prev(slot_prev(cur_slot_q));
	assign p_slot = in_flush_q ? cur_slot_q : slot_prev(cur_slot_q);
	assign cp     = (pt_col_q == np_m1) ? '0 : pt_col_q + CW'(1);
	assign cm     = (pt_col_q == '0) ? np_m1 : pt_col_q - CW'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && r_cur != '0) begin
					state_d = ST_RD_T;
				end
			end
			ST_RD_T: state_d = ST_RD_P;
			ST_RD_P: state_d = ST_MTL;
			ST_MTL:  state_d = ST_MTH;
			ST_MTH:  state_d = ST_MPL;
			ST_MPL:  state_d = ST_MPH;
			ST_MPH:  state_d = ST_MACC;
			ST_MACC: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = more ? ST_RD_T : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.acc_op   = ACC_HOLD;
		cmd.sh17     = !(in_flush_q || fwd_q);
		cmd.row      = ROW_W'(pt_row_q);
		cmd.col      = COL_W'(pt_col_q);
		cmd.final_pt = pt_final_q;
		wr_addr      = mem_addr(s_cur, c_cur);
		rd_addr0     = mem_addr(cur_slot_q, pt_col_q);
		rd_addr1     = mem_addr(b_slot, pt_col_q);
		unique case (state_q)
			ST_IDLE: cmd.wr_en = accept;
			ST_RD_T: cmd.rd_en = 1'b1;
			ST_RD_P: begin
				cmd.rd_en = 1'b1;
				cmd.lat_t = 1'b1;
				rd_addr0  = mem_addr(p_slot, cp);
				rd_addr1  = mem_addr(p_slot, cm);
			end
			ST_MTL: begin
				cmd.lat_p  = 1'b1;
				cmd.mul_en = 1'b1;
			end
			ST_MTH: begin
				cmd.acc_op = ACC_LOAD;
				cmd.mul_en = 1'b1;
				cmd.mul_hi = 1'b1;
			end
			ST_MPL: begin
				cmd.acc_op = ACC_ADD;
				cmd.mul_en = 1'b1;
				cmd.mul_p  = 1'b1;
			end
			ST_MPH: begin
				cmd.sav_t  = 1'b1;
				cmd.acc_op = ACC_LOAD;
				cmd.mul_en = 1'b1;
				cmd.mul_p  = 1'b1;
				cmd.mul_hi = 1'b1;
			end
			ST_MACC: cmd.acc_op = ACC_ADD;
			ST_OUT:  cmd.out_load = out_free;
			default: cmd.acc_op = ACC_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			col_q       <= '0;
			slot_q      <= 2'd0;
			cur_slot_q  <= 2'd0;
			pt_row_q    <= '0;
			last_row_q  <= '0;
			pt_col_q    <= '0;
			fwd_q       <= 1'b0;
			flush_q     <= 1'b0;
			in_flush_q  <= 1'b0;
			pt_final_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (is_last) begin
					row_q  <= '0;
					col_q  <= '0;
					slot_q <= 2'd0;
				end else if (col_end) begin
					row_q  <= r_cur + RW'(1);
					col_q  <= '0;
					slot_q <= slot_next(s_cur);
				end else begin
					row_q  <= r_cur;
					col_q  <= c_cur + CW'(1);
					slot_q <= s_cur;
				end
				cur_slot_q <= s_cur;
				pt_row_q   <= r_cur - RW'(1);
				last_row_q <= r_cur;
				pt_col_q   <= c_cur;
				fwd_q      <= (r_cur == RW'(1));
				flush_q    <= is_last;
				in_flush_q <= 1'b0;
				pt_final_q <= 1'b0;
			end else if (state_q == ST_OUT && out_free && more) begin
				if (!in_flush_q) begin
					in_flush_q <= 1'b1;
					pt_row_q   <= last_row_q;
					pt_col_q   <= '0;
					pt_final_q <= 1'b0;
				end else begin
					pt_col_q   <= pt_col_q + CW'(1);
					pt_final_q <= (pt_col_q + CW'(1) == np_m1);
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q != 2'd3 && cur_slot_q != 2'd3)
		else $error("row slot out of ring");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not presented");
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.final_pt) |=> state_q == ST_IDLE)
		else $error("sequencer busy after last point");
	a_flush_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && in_flush_q) |-> 32'(pt_row_q) == 32'(nt) - 32'd1)
		else $error("flush point outside last row");
`endif

endmodule

// ===== rtl/mesh_partial_derivatives_unit.sv =====
// Top level of the mesh partial derivatives unit: configuration registers,
// controller and datapath. Depends on mpd_pkg, mpd_ctrl, mpd_datapath.
//
// Samples stream in row-major order (theta rows outer, phi columns inner) as
// signed Q16.16. Point (r,c) is produced when sample (r+1,c) is taken, with a
// forward theta difference on the first row, centered differences inside,
// a backward theta difference on the last row and a periodic centered phi
// difference; the last sample of the mesh also drains the whole last row.
// A sample of row 0 is only stored; any other sample runs the per-point
// sequence, and the last sample of a mesh runs it again for each column of
// the last row. No sample is taken until the sequence ends. The sequence is
// two reads of the two-port row store, four passes through the single 17x33
// multiplier, the closing accumulate step and the output load; a stalled
// output adds its stall. Configuration writes are for idle periods only.
module mesh_partial_derivatives_unit #(
	parameter int MAX_PHI   = mpd_pkg::MAX_PHI_DEF,
	parameter int MAX_THETA = mpd_pkg::MAX_THETA_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [mpd_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [mpd_pkg::DATA_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [mpd_pkg::DATA_W-1:0] sample,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mpd_pkg::DATA_W-1:0] d_theta,
	output logic signed [mpd_pkg::DATA_W-1:0] d_phi,
	output logic [mpd_pkg::ROW_W-1:0]         row,
	output logic [mpd_pkg::COL_W-1:0]         col,
	output logic                              clipped,
	output logic                              final_point
);
	import mpd_pkg::*;

	localparam int AW = $clog2(3 * MAX_PHI);

	logic [NT_W-1:0]   n_theta_q;
	logic [NP_W-1:0]   n_phi_q;
	logic [DATA_W-1:0] inv_dtheta_q, inv_dphi_q;
	mpd_cmd_t          cmd;
	logic [AW-1:0]     wr_addr, rd_addr0, rd_addr1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_theta_q    <= N_THETA_RST;
			n_phi_q      <= N_PHI_RST;
			inv_dtheta_q <= INV_RST;
			inv_dphi_q   <= INV_RST;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				REG_N_THETA:    n_theta_q    <= cfg_data[NT_W-1:0];
				REG_N_PHI:      n_phi_q      <= cfg_data[NP_W-1:0];
				REG_INV_DTHETA: inv_dtheta_q <= cfg_data;
				REG_INV_DPHI:   inv_dphi_q   <= cfg_data;
				default:        inv_dphi_q   <= inv_dphi_q;
			endcase
		end
	end

	mpd_ctrl #(
		.MAX_PHI  (MAX_PHI),
		.MAX_THETA(MAX_THETA)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.n_theta  (n_theta_q),
		.n_phi    (n_phi_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr0 (rd_addr0),
		.rd_addr1 (rd_addr1)
	);

	mpd_datapath #(
		.MAX_PHI(MAX_PHI)
	) u_datapath (
		.clk        (clk),
		.cmd        (cmd),
		.wr_addr    (wr_addr),
		.rd_addr0   (rd_addr0),
		.rd_addr1   (rd_addr1),
		.sample     (sample),
		.inv_dtheta (inv_dtheta_q),
		.inv_dphi   (inv_dphi_q),
		.d_theta    (d_theta),
		.d_phi      (d_phi),
		.row        (row),
		.col        (col),
		.clipped    (clipped),
		.final_point(final_point)
	);

endmodule

// ===== tb/sv/tb_mesh_partial_derivatives_unit.sv =====
// Testbench for mesh_partial_derivatives_unit: streams meshes of samples through
// random gaps and stalls and checks each gradient point against a predictor.
// Depends on mpd_pkg and the RTL of the unit.
module tb_mesh_partial_derivatives_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import mpd_pkg::*;

	localparam int          RANDOM_ITEMS   = 230;
	localparam int unsigned GAP_MAX        = 17;
	localparam int          SETTLE_CYCLES  = 24;
	localparam int          WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic signed [DATA_W-1:0] d_theta;
		logic signed [DATA_W-1:0] d_phi;
		logic [ROW_W-1:0]         row;
		logic [COL_W-1:0]         col;
		logic                     clipped;
		logic                     final_point;
	} gradient_t;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     cfg_wen     = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_addr    = '0;
	logic [DATA_W-1:0]        cfg_data    = '0;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic signed [DATA_W-1:0] sample      = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic signed [DATA_W-1:0] d_theta;
	logic signed [DATA_W-1:0] d_phi;
	logic [ROW_W-1:0]         row;
	logic [COL_W-1:0]         col;
	logic                     clipped;
	logic                     final_point;

	// predictor state
	logic [DATA_W-1:0] row_ring [3][MAX_PHI_DEF];
	int unsigned       mesh_row = 0;
	int unsigned       mesh_col = 0;
	logic [NT_W-1:0]   cfg_nt    = N_THETA_RST;
	logic [NP_W-1:0]   cfg_np    = N_PHI_RST;
	logic [DATA_W-1:0] cfg_inv_t = INV_RST;
	logic [DATA_W-1:0] cfg_inv_p = INV_RST;

	logic [DATA_W-1:0] sample_q [$];
	gradient_t         grad_q [$];
	logic [DATA_W-1:0] smooth_level = '0;

	int unsigned in_hold   = 0;
	int unsigned out_hold  = 0;
	bit          in_burst  = 1'b0;
	bit          out_burst = 1'b0;
	int          idle_cycles = 0;
	bit          failed = 1'b0;

	mesh_partial_derivatives_unit dut (.*);

	always #1 clk = ~clk;

	function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
		return (v < 2) ? 2 : ((v > hi) ? hi : v);
	endfunction

	function automatic longint stored(int unsigned r, int unsigned c);
		logic signed [DATA_W-1:0] w;
		w = row_ring[r % 3][c % MAX_PHI_DEF];
		return w;
	endfunction

	// diff * inv, arithmetic shift right by sh, saturate; bit 32 flags saturation
	function automatic logic [DATA_W:0] scaled(longint diff, logic [DATA_W-1:0] inv,
		int unsigned sh);
		logic [63:0] mag;
		logic [63:0] prod;
		logic [63:0] q;
		mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
		prod = mag * {32'd0, inv};
		if (diff >= 0) begin
			q = prod >> sh;
			if (q > 64'h7FFF_FFFF)
				return {1'b1, 32'h7FFF_FFFF};
			return {1'b0, q[31:0]};
		end
		q = (prod + ((64'd1 << sh) - 64'd1)) >> sh;
		if (q > 64'h8000_0000)
			return {1'b1, 32'h8000_0000};
		return {1'b0, 32'd0 - q[31:0]};
	endfunction

	function automatic void push_gradient(int unsigned r, int unsigned c, int unsigned nt,
		int unsigned np, bit is_last);
		int unsigned cp;
		int unsigned cm;
		int unsigned sh;
		longint      dt;
		logic [DATA_W:0] t;
		logic [DATA_W:0] p;
		gradient_t   g;
		cp = (c + 1 == np) ? 0 : c + 1;
		cm = (c == 0) ? np - 1 : c - 1;
		if (r == 0) begin
			dt = stored(1, c) - stored(0, c);
			sh = 16;
		end else if (r == nt - 1) begin
			dt = stored(r, c) - stored(r - 1, c);
			sh = 16;
		end else begin
			dt = stored(r + 1, c) - stored(r - 1, c);
			sh = 17;
		end
		t = scaled(dt, cfg_inv_t, sh);
		p = scaled(stored(r, cp) - stored(r, cm), cfg_inv_p, 17);
		g.d_theta     = t[DATA_W-1:0];
		g.d_phi       = p[DATA_W-1:0];
		g.row         = ROW_W'(r);
		g.col         = COL_W'(c);
		g.clipped     = t[DATA_W] | p[DATA_W];
		g.final_point = is_last;
		grad_q.push_back(g);
	endfunction

	function automatic void advance_mesh(logic [DATA_W-1:0] s);
		int unsigned nt;
		int unsigned np;
		int unsigned c;
		nt = clamp_size(cfg_nt, MAX_THETA_DEF);
		np = clamp_size(cfg_np, MAX_PHI_DEF);
		if (mesh_row >= nt || mesh_col >= np) begin
			mesh_row = 0;
			mesh_col = 0;
		end
		row_ring[mesh_row % 3][mesh_col] = s;
		if (mesh_row >= 1)
			push_gradient(mesh_row - 1, mesh_col, nt, np, 1'b0);
		if (mesh_row == nt - 1 && mesh_col == np - 1) begin
			for (c = 0; c < np; c++)
				push_gradient(mesh_row, c, nt, np, c == np - 1);
			mesh_row = 0;
			mesh_col = 0;
		end else begin
			mesh_col++;
			if (mesh_col == np) begin
				mesh_col = 0;
				mesh_row++;
			end
		end
	endfunction

	function automatic void compare_field(string name, logic [DATA_W-1:0] want,
		logic [DATA_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, actual %h", $time, name, want, got);
			failed = 1'b1;
		end
	endfunction

	function automatic void check_gradient();
		gradient_t want;
		if (grad_q.size() == 0) begin
			$display("%0t: unexpected transaction row %0d col %0d", $time, row, col);
			failed = 1'b1;
		end else begin
			want = grad_q.pop_front();
			compare_field("d_theta", want.d_theta, d_theta);
			compare_field("d_phi", want.d_phi, d_phi);
			compare_field("row", 32'(want.row), 32'(row));
			compare_field("col", 32'(want.col), 32'(col));
			compare_field("clipped", 32'(want.clipped), 32'(clipped));
			compare_field("final_point", 32'(want.final_point), 32'(final_point));
		end
	endfunction

	function automatic int unsigned draw_gap(inout bit burst);
		if ($urandom_range(0, 19) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, GAP_MAX);
	endfunction

	function automatic logic [DATA_W-1:0] mesh_value();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			1, 2, 3: return $urandom();
			default: begin
				smooth_level = smooth_level + 32'($urandom_range(0, 262143)) - 32'd131072;
				return smooth_level;
			end
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] pick_inv();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return INV_RST;
			3: return $urandom_range(0, 1048576);
			default: return $urandom();
		endcase
	endfunction

	// unused upper bits of a size write
	function automatic logic [DATA_W-1:0] size_noise(logic [DATA_W-1:0] mask);
		return ($urandom_range(0, 3) == 0) ? ($urandom() & ~mask) : '0;
	endfunction

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		cfg_wen  <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_N_THETA:    cfg_nt    = val[NT_W-1:0];
			REG_N_PHI:      cfg_np    = val[NP_W-1:0];
			REG_INV_DTHETA: cfg_inv_t = val;
			REG_INV_DPHI:   cfg_inv_p = val;
			default: ;
		endcase
	endtask

	task automatic load_config(logic [DATA_W-1:0] nt, logic [DATA_W-1:0] np,
		logic [DATA_W-1:0] inv_t, logic [DATA_W-1:0] inv_p);
		set_reg(REG_N_THETA, nt);
		set_reg(REG_N_PHI, np);
		set_reg(REG_INV_DTHETA, inv_t);
		set_reg(REG_INV_DPHI, inv_p);
		@(negedge clk);
	endtask

	// all samples taken, all points drained, then let the unit finish a row-0 sample
	task automatic settle();
		while (sample_q.size() != 0 || in_valid || grad_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			advance_mesh(sample);
			in_hold = draw_gap(in_burst);
		end
		if (!in_valid || in_ready) begin
			if (in_hold != 0) begin
				in_hold--;
				in_valid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				in_valid <= 1'b1;
				sample   <= sample_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			check_gradient();
			out_hold = draw_gap(out_burst);
		end else if (out_hold != 0) begin
			out_hold--;
		end
		out_ready <= (out_hold == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d points outstanding", $time, grad_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int unsigned nt_w;
		int unsigned np_w;
		int unsigned nt_eff;
		int unsigned np_eff;
		int unsigned count;
		int unsigned random_items;
		bit          restart_pending;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		settle();

		// reset sizes, full-scale swings
		sample_q = {sample_q, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
		settle();

		// centered row, largest reciprocals: saturation both ways, rounding of negatives
		load_config(32'd3, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		sample_q = {sample_q, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000,
			32'hFFFF_0000, 32'h0000_0003, 32'h8000_0000};
		settle();

		// oversized theta clamps to the maximum; leave the mesh unfinished
		load_config(32'd8191, 32'd2, 32'h0000_0000, 32'h0000_0001);
		sample_q = {sample_q, 32'h0000_0005, 32'hFFFF_FFFD, 32'h7FFF_FFFF,
			32'h0000_0000, 32'h8000_0001, 32'h1234_5678};
		settle();

		// undersized sizes clamp to 2; counters beyond the new sizes force a restart
		load_config(32'd1, 32'd0, 32'h0000_0003, 32'h0002_8000);
		sample_q = {sample_q, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_0000, 32'h8000_FFFF};

		random_items    = 0;
		restart_pending = 1'b0;
		while (random_items < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 7))
				0: np_w = $urandom_range(0, 1);
				1: np_w = $urandom_range(33, 63);
				2: np_w = MAX_PHI_DEF;
				default: np_w = $urandom_range(2, 8);
			endcase
			np_eff = clamp_size(np_w, MAX_PHI_DEF);
			if (restart_pending || $urandom_range(0, 5) == 0)
				nt_w = $urandom_range(0, 2);
			else if (np_eff > 8)
				nt_w = 3;
			else
				nt_w = $urandom_range(3, 6);
			nt_eff = clamp_size(nt_w, MAX_THETA_DEF);
			load_config(32'(nt_w) | size_noise(32'h0000_1FFF),
				32'(np_w) | size_noise(32'h0000_003F), pick_inv(), pick_inv());
			count = ((np_eff > 8) ? 1 : $urandom_range(1, 2)) * nt_eff * np_eff;
			restart_pending = 1'b0;
			// truncated mesh, abandoned by the next phase
			if (nt_eff >= 3 && $urandom_range(0, 3) == 0) begin
				count += $urandom_range(2 * np_eff, nt_eff * np_eff - 1);
				restart_pending = 1'b1;
			end
			repeat (count) sample_q.push_back(mesh_value());
			random_items += count;
		end

		settle();
		if (!failed)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
